FILE: design/lci_pkg.sv
package lci_pkg;

  localparam int BW    = 49;  // b = x*cx + y*cy, signed
  localparam int AW    = 32;  // a = cx^2 + cy^2, unsigned
  localparam int RadW  = 94;  // discriminant, unsigned
  localparam int RootW = 47;  // floor(sqrt(disc))
  localparam int MagW  = 49;  // |numerator|

  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] path_param;
    logic               no_hit;
  } out_word_t;

  // Track data that rides along with the divider.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic               no_hit;
  } dv_side_t;

  // Track data that rides along with the square root.
  typedef struct packed {
    dv_side_t              trk;
    logic signed [BW-1:0]  b;
    logic [AW-1:0]         a;
  } sq_side_t;

endpackage

FILE: design/line_cylinder_intersection_top.sv
// Intersects a straight track with a cylinder of programmable radius around
// the z axis and returns the path parameter of the chosen root and the hit
// point.
// The input channel takes one word per track (vertex in Q16.16, direction
// cosines in Q2.14); the output channel returns one word per track with the
// saturated t, the hit point and no_hit.
// The radius is written through the cfg channel, which is always ready; write
// it only while no track is in flight.
// The pipeline has five stages of products and discriminant, 47 square-root
// stages (one root bit each), one numerator stage, 33 divider stages (an
// input register, then one quotient bit each) and three output stages.
// Throughput is one word per cycle while the output is not stalled; the
// square root and the divider are fully pipelined.
// When the receiver stalls while a word is held on the output, the whole
// pipeline freezes and in_stall rises in the same cycle; nothing is lost.
// Reset clears all valid bits and sets the radius to zero.
module line_cylinder_intersection_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lci_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lci_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data
);

  logic en;

  logic [30:0] cfg_r;
  logic [61:0] r2_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      r2_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      r2_r <= 62'(cfg_r) * 62'(cfg_r);
    end
  end

  // Stage 1: squared transverse direction norm and the vertex-direction products.
  logic                     s1_vld_r;
  lci_pkg::in_word_t        s1_w_r;
  logic [lci_pkg::AW-1:0]   s1_a_r;
  logic signed [47:0]       s1_px_r, s1_py_r, s1_qx_r, s1_qy_r;
  logic signed [31:0]       sqx, sqy;
  logic signed [47:0]       px_nxt, py_nxt, qx_nxt, qy_nxt;

  assign sqx    = in_word.dir_x * in_word.dir_x;
  assign sqy    = in_word.dir_y * in_word.dir_y;
  assign px_nxt = 48'(in_word.vertex_x) * 48'(in_word.dir_x);
  assign py_nxt = 48'(in_word.vertex_y) * 48'(in_word.dir_y);
  assign qx_nxt = 48'(in_word.vertex_x) * 48'(in_word.dir_y);
  assign qy_nxt = 48'(in_word.vertex_y) * 48'(in_word.dir_x);

  // Stage 2: b and |d| with d = x*cy - y*cx.
  logic                     s2_vld_r;
  lci_pkg::in_word_t        s2_w_r;
  logic [lci_pkg::AW-1:0]   s2_a_r;
  logic signed [lci_pkg::BW-1:0] s2_b_r;
  logic [47:0]              s2_absd_r;
  logic signed [48:0]       d_nxt;
  logic [48:0]              absd_nxt;

  assign d_nxt    = 49'(s1_qx_r) - 49'(s1_qy_r);
  assign absd_nxt = d_nxt[48] ? 49'(-d_nxt) : 49'(d_nxt);

  // Stage 3: partial products of a*R^2 and d^2.
  logic                     s3_vld_r;
  lci_pkg::in_word_t        s3_w_r;
  logic [lci_pkg::AW-1:0]   s3_a_r;
  logic signed [lci_pkg::BW-1:0] s3_b_r;
  logic [63:0]              s3_palo_r;
  logic [61:0]              s3_pahi_r;
  logic [63:0]              s3_dll_r;
  logic [47:0]              s3_dhl_r;
  logic [31:0]              s3_dhh_r;

  // Stage 4: assemble a*R^2 and d^2.
  logic                     s4_vld_r;
  lci_pkg::in_word_t        s4_w_r;
  logic [lci_pkg::AW-1:0]   s4_a_r;
  logic signed [lci_pkg::BW-1:0] s4_b_r;
  logic [93:0]              s4_ar2_r;
  logic [95:0]              s4_d2_r;

  // Stage 5: discriminant and the miss test.
  logic                     s5_vld_r;
  logic [lci_pkg::RadW-1:0] s5_disc_r;
  lci_pkg::sq_side_t        s5_side_r;
  logic [95:0]              disc_full;
  logic                     miss;

  assign disc_full = {2'b00, s4_ar2_r} - s4_d2_r;
  assign miss      = (s4_a_r == '0) || ({2'b00, s4_ar2_r} < s4_d2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w_r    <= in_word;
      s1_a_r    <= 32'(sqx) + 32'(sqy);
      s1_px_r   <= px_nxt;
      s1_py_r   <= py_nxt;
      s1_qx_r   <= qx_nxt;
      s1_qy_r   <= qy_nxt;

      s2_w_r    <= s1_w_r;
      s2_a_r    <= s1_a_r;
      s2_b_r    <= 49'(s1_px_r) + 49'(s1_py_r);
      s2_absd_r <= absd_nxt[47:0];

      s3_w_r    <= s2_w_r;
      s3_a_r    <= s2_a_r;
      s3_b_r    <= s2_b_r;
      s3_palo_r <= 64'(s2_a_r) * 64'(r2_r[31:0]);
      s3_pahi_r <= 62'(s2_a_r) * 62'(r2_r[61:32]);
      s3_dll_r  <= 64'(s2_absd_r[31:0]) * 64'(s2_absd_r[31:0]);
      s3_dhl_r  <= 48'(s2_absd_r[47:32]) * 48'(s2_absd_r[31:0]);
      s3_dhh_r  <= 32'(s2_absd_r[47:32]) * 32'(s2_absd_r[47:32]);

      s4_w_r    <= s3_w_r;
      s4_a_r    <= s3_a_r;
      s4_b_r    <= s3_b_r;
      s4_ar2_r  <= (94'(s3_pahi_r) << 32) + 94'(s3_palo_r);
      s4_d2_r   <= (96'(s3_dhh_r) << 64) + (96'(s3_dhl_r) << 33) + 96'(s3_dll_r);

      s5_disc_r           <= miss ? '0 : disc_full[lci_pkg::RadW-1:0];
      s5_side_r.b         <= s4_b_r;
      s5_side_r.a         <= s4_a_r;
      s5_side_r.trk.vx    <= s4_w_r.vertex_x;
      s5_side_r.trk.vy    <= s4_w_r.vertex_y;
      s5_side_r.trk.vz    <= s4_w_r.vertex_z;
      s5_side_r.trk.cx    <= s4_w_r.dir_x;
      s5_side_r.trk.cy    <= s4_w_r.dir_y;
      s5_side_r.trk.cz    <= s4_w_r.dir_z;
      s5_side_r.trk.no_hit <= miss;
    end
  end

  logic                      sq_vld;
  logic [lci_pkg::RootW-1:0] sq_root;
  lci_pkg::sq_side_t         sq_side;

  lci_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s5_vld_r),
    .in_rad   (s5_disc_r),
    .in_side  (s5_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Numerator: take -b + s unless it is negative, then -b - s.
  logic                      nm_vld_r;
  logic [lci_pkg::MagW-1:0]  nm_mag_r;
  logic                      nm_neg_r;
  logic [lci_pkg::AW-1:0]    nm_a_r;
  lci_pkg::dv_side_t         nm_side_r;
  logic signed [49:0]        nb, sx, np, nn, num;
  logic [49:0]               num_abs;

  assign nb      = -(50'(sq_side.b));
  assign sx      = $signed({3'b000, sq_root});
  assign np      = nb + sx;
  assign nn      = nb - sx;
  assign num     = np[49] ? nn : np;
  assign num_abs = num[49] ? 50'(-num) : 50'(num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else if (en) begin
      nm_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_mag_r  <= num_abs[lci_pkg::MagW-1:0];
      nm_neg_r  <= num[49];
      nm_a_r    <= sq_side.a;
      nm_side_r <= sq_side.trk;
    end
  end

  logic              dv_vld;
  logic [31:0]       dv_q;
  logic              dv_ovf;
  logic              dv_neg;
  lci_pkg::dv_side_t dv_side;

  lci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (nm_vld_r),
    .in_mag   (nm_mag_r),
    .in_neg   (nm_neg_r),
    .in_a     (nm_a_r),
    .in_side  (nm_side_r),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_ovf  (dv_ovf),
    .out_neg  (dv_neg),
    .out_side (dv_side)
  );

  // P1: signed, saturated t.
  logic               p1_vld_r;
  logic signed [31:0] p1_t_r;
  lci_pkg::dv_side_t  p1_side_r;
  logic signed [31:0] t_nxt;

  always_comb begin
    priority if (dv_ovf) begin
      t_nxt = dv_neg ? lci_pkg::SatMin : lci_pkg::SatMax;
    end else if (!dv_neg) begin
      t_nxt = dv_q[31] ? lci_pkg::SatMax : $signed(dv_q);
    end else if (dv_q > 32'h8000_0000) begin
      t_nxt = lci_pkg::SatMin;
    end else begin
      t_nxt = $signed(32'h0 - dv_q);
    end
  end

  // P2: direction times t.
  logic               p2_vld_r;
  logic signed [31:0] p2_t_r;
  logic signed [47:0] p2_mx_r, p2_my_r, p2_mz_r;
  lci_pkg::dv_side_t  p2_side_r;

  // P3: the output register.
  logic               out_valid_r;
  lci_pkg::out_word_t out_word_r;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] v,
                                                 logic signed [47:0] m);
    logic signed [34:0] s;
    s = 35'(v) + 35'(m >>> 14);
    if (s > 35'(lci_pkg::SatMax)) begin
      return lci_pkg::SatMax;
    end else if (s < 35'(lci_pkg::SatMin)) begin
      return lci_pkg::SatMin;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_vld_r    <= dv_vld;
      p2_vld_r    <= p1_vld_r;
      out_valid_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_t_r    <= t_nxt;
      p1_side_r <= dv_side;

      p2_t_r    <= p1_t_r;
      p2_mx_r   <= 48'(p1_side_r.cx) * 48'(p1_t_r);
      p2_my_r   <= 48'(p1_side_r.cy) * 48'(p1_t_r);
      p2_mz_r   <= 48'(p1_side_r.cz) * 48'(p1_t_r);
      p2_side_r <= p1_side_r;

      if (p2_side_r.no_hit) begin
        out_word_r.hit_x      <= '0;
        out_word_r.hit_y      <= '0;
        out_word_r.hit_z      <= '0;
        out_word_r.path_param <= '0;
      end else begin
        out_word_r.hit_x      <= sat_add(p2_side_r.vx, p2_mx_r);
        out_word_r.hit_y      <= sat_add(p2_side_r.vy, p2_my_r);
        out_word_r.hit_z      <= sat_add(p2_side_r.vz, p2_mz_r);
        out_word_r.path_param <= p2_t_r;
      end
      out_word_r.no_hit <= p2_side_r.no_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.no_hit) |->
      (out_word.path_param == '0 && out_word.hit_x == '0 &&
       out_word.hit_y == '0 && out_word.hit_z == '0))
    else $error("missed track carries nonzero fields");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_valid && !in_stall)) |-> s1_vld_r)
    else $error("accepted word did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(!en)) |->
      (s1_vld_r == $past(s1_vld_r) && p2_vld_r == $past(p2_vld_r)))
    else $error("pipeline moved while frozen");

endmodule

FILE: design/lci_sqrt.sv
module lci_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [lci_pkg::RadW-1:0]     in_rad,
  input  lci_pkg::sq_side_t            in_side,
  output logic                         out_vld,
  output logic [lci_pkg::RootW-1:0]    out_root,
  output lci_pkg::sq_side_t            out_side
);

  localparam int Steps = lci_pkg::RootW;
  localparam int RemW  = lci_pkg::RootW + 2;

  logic                      vld_r  [1:Steps];
  logic [RemW-1:0]           rem_r  [1:Steps];
  logic [lci_pkg::RootW-1:0] root_r [1:Steps];
  logic [lci_pkg::RadW-1:0]  rad_r  [1:Steps];
  lci_pkg::sq_side_t         side_r [1:Steps];

  // One result bit per stage, restoring square root on digit pairs.
  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic                      vld_c;
    logic [RemW-1:0]           rem_c;
    logic [lci_pkg::RootW-1:0] root_c;
    logic [lci_pkg::RadW-1:0]  rad_c;
    lci_pkg::sq_side_t         side_c;
    logic [RemW+1:0]           cur;
    logic [RemW+1:0]           trial;
    logic [RemW+1:0]           diff;
    logic                      ge;

    if (g == 0) begin : g_first
      assign vld_c  = in_vld;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = in_rad;
      assign side_c = in_side;
    end else begin : g_next
      assign vld_c  = vld_r[g];
      assign rem_c  = rem_r[g];
      assign root_c = root_r[g];
      assign rad_c  = rad_r[g];
      assign side_c = side_r[g];
    end

    assign cur   = {rem_c, rad_c[lci_pkg::RadW-1 -: 2]};
    assign trial = {2'b00, root_c, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
        root_r[g+1] <= {root_c[lci_pkg::RootW-2:0], ge};
        rad_r[g+1]  <= {rad_c[lci_pkg::RadW-3:0], 2'b00};
        side_r[g+1] <= side_c;
      end
    end
  end

  assign out_vld  = vld_r[Steps];
  assign out_root = root_r[Steps];
  assign out_side = side_r[Steps];

endmodule

FILE: design/lci_div.sv
module lci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [lci_pkg::MagW-1:0]   in_mag,
  input  logic                       in_neg,
  input  logic [lci_pkg::AW-1:0]     in_a,
  input  lci_pkg::dv_side_t          in_side,
  output logic                       out_vld,
  output logic [31:0]                out_q,
  output logic                       out_ovf,
  output logic                       out_neg,
  output lci_pkg::dv_side_t          out_side
);

  localparam int Steps = 32;
  localparam int NW    = lci_pkg::MagW + 14;

  logic                    vld_r  [0:Steps];
  logic [31:0]             rem_r  [0:Steps];
  logic [31:0]             low_r  [0:Steps];
  logic [31:0]             q_r    [0:Steps];
  logic [lci_pkg::AW-1:0]  a_r    [0:Steps];
  logic                    ovf_r  [0:Steps];
  logic                    neg_r  [0:Steps];
  lci_pkg::dv_side_t       side_r [0:Steps];

  logic [NW-1:0] n;
  logic          ovf;

  // Numerator is scaled by 2^14; a quotient of 2^32 or more only saturates.
  assign n   = {in_mag, 14'b0};
  assign ovf = {1'b0, n} >= {in_a, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, n[NW-1:32]};
      low_r[0]  <= n[31:0];
      q_r[0]    <= '0;
      a_r[0]    <= in_a;
      ovf_r[0]  <= ovf;
      neg_r[0]  <= in_neg;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic [32:0] cur;
    logic [32:0] diff;
    logic        ge;

    assign cur  = {rem_r[g], low_r[g][31]};
    assign ge   = cur >= {1'b0, a_r[g]};
    assign diff = cur - {1'b0, a_r[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? diff[31:0] : cur[31:0];
        low_r[g+1]  <= {low_r[g][30:0], 1'b0};
        q_r[g+1]    <= {q_r[g][30:0], ge};
        a_r[g+1]    <= a_r[g];
        ovf_r[g+1]  <= ovf_r[g];
        neg_r[g+1]  <= neg_r[g];
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_vld  = vld_r[Steps];
  assign out_q    = q_r[Steps];
  assign out_ovf  = ovf_r[Steps];
  assign out_neg  = neg_r[Steps];
  assign out_side = side_r[Steps];

endmodule
